// ===== rtl/lcg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared constants and controller/datapath command types for the LCG block.
// ----------------------------------------------------------------------------
package lcg_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd2;

    // multiplier reset value, truncated to the state width where it is used
    localparam logic [63:0] MULT_RESET = 64'd44485709377909;

    // input word mode codes
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    typedef struct packed {
        logic start;     // word accepted: capture operands, run checks
        logic step;      // one multiplier bit
        logic add_inc;   // add increment mod m
        logic load_out;  // commit state and fill output register
    } t_dp_cmd;

    typedef struct packed {
        logic direct;    // load or refused step: no multiply needed
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/lcg_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_in_if
// Command channel: mode and seed word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcg_in_if #(
    parameter int W = 48
);
    logic         valid;
    logic         ready;
    logic         mode;
    logic [W-1:0] seed_value;

    modport source (output valid, output mode, output seed_value, input ready);
    modport sink   (input valid, input mode, input seed_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcg_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_out_if
// Result channel: generator value and error flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcg_out_if #(
    parameter int W = 48
);
    logic         valid;
    logic         ready;
    logic [W-1:0] value;
    logic         error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_ctrl
// Sequencer: accepts a word, runs the bit-serial multiply, commits the result.
// ----------------------------------------------------------------------------
module lcg_ctrl #(
    parameter int WIDTH = 48
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    input  wire lcg_pkg::t_dp_sts  i_sts,
    output lcg_pkg::t_dp_cmd       o_cmd
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             commit;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    // output register free, or being drained this cycle
    assign commit      = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = i_sts.direct ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.add_inc = 1'b1;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                if (commit) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("lcg_ctrl: still idle after accepting a word");

    a_commit_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> ((r_state == ST_FIN) && (!r_out_valid || i_out_ready)))
        else $error("lcg_ctrl: output loaded outside of commit");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("lcg_ctrl: pending result dropped");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt <= CNT_LAST))
        else $error("lcg_ctrl: bit counter past last multiplier bit");
`endif

endmodule
`default_nettype wire

// ===== rtl/lcg_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_datapath
// Config registers, range checks, shift-and-add modular multiplier, state.
// ----------------------------------------------------------------------------
module lcg_datapath #(
    parameter int WIDTH = 48
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [lcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [WIDTH:0]               i_cfg_data,
    input  wire                          i_mode,
    input  wire  [WIDTH-1:0]             i_seed_value,
    input  wire  lcg_pkg::t_dp_cmd       i_cmd,
    output lcg_pkg::t_dp_sts             o_sts,
    output logic [WIDTH-1:0]             o_value,
    output logic                         o_error
);

    localparam logic [WIDTH:0] MOD_TOP = {1'b1, {WIDTH{1'b0}}};

    logic [WIDTH-1:0] r_mult;
    logic [WIDTH-1:0] r_inc;
    logic [WIDTH:0]   r_modulus;
    logic [WIDTH-1:0] r_seed;

    logic [WIDTH:0]   r_m;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_addend;
    logic [WIDTH-1:0] r_k;
    logic             r_err;
    logic             r_mode;
    logic [WIDTH-1:0] r_seed_in;
    logic [WIDTH-1:0] r_out_value;
    logic             r_out_err;

    logic [WIDTH:0]   m_eff;
    logic             chk_err;
    logic [WIDTH-1:0] acc_opnd;
    logic [WIDTH-1:0] acc_sum;
    logic [WIDTH-1:0] dbl_sum;
    logic [WIDTH-1:0] result;

    // x + y mod m for x, y below m; one conditional subtract
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH:0]   m
    );
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= m) begin
            s = s - m;
        end
        return s[WIDTH-1:0];
    endfunction

    // modulus above two to the WIDTH is clamped
    assign m_eff = (r_modulus[WIDTH] && (|r_modulus[WIDTH-1:0])) ? MOD_TOP : r_modulus;

    always_comb begin
        if (m_eff == '0) begin
            chk_err = 1'b1;
        end else if (i_mode == lcg_pkg::MODE_LOAD) begin
            chk_err = ({1'b0, i_seed_value} >= m_eff);
        end else begin
            chk_err = ({1'b0, r_inc} >= m_eff) || ({1'b0, r_seed} >= m_eff);
        end
    end

    assign o_sts.direct = chk_err || (i_mode == lcg_pkg::MODE_LOAD);

    assign acc_opnd = i_cmd.add_inc ? r_inc : r_addend;
    assign acc_sum  = add_mod(r_acc, acc_opnd, r_m);
    assign dbl_sum  = add_mod(r_addend, r_addend, r_m);

    always_comb begin
        if (r_err) begin
            result = r_seed;
        end else if (r_mode == lcg_pkg::MODE_LOAD) begin
            result = r_seed_in;
        end else begin
            result = r_acc;
        end
    end

    // config registers and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult    <= lcg_pkg::MULT_RESET[WIDTH-1:0];
            r_inc     <= '0;
            r_modulus <= MOD_TOP;
            r_seed    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lcg_pkg::CFG_MULTIPLIER: r_mult    <= i_cfg_data[WIDTH-1:0];
                    lcg_pkg::CFG_INCREMENT:  r_inc     <= i_cfg_data[WIDTH-1:0];
                    lcg_pkg::CFG_MODULUS:    r_modulus <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_seed <= result;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_err     <= chk_err;
            r_mode    <= i_mode;
            r_seed_in <= i_seed_value;
            r_m       <= m_eff;
            r_acc     <= '0;
            r_addend  <= r_seed;
            r_k       <= r_mult;
        end
        if (i_cmd.step) begin
            if (r_k[0]) begin
                r_acc <= acc_sum;
            end
            r_addend <= dbl_sum;
            r_k      <= {1'b0, r_k[WIDTH-1:1]};
        end
        if (i_cmd.add_inc) begin
            r_acc <= acc_sum;
        end
        if (i_cmd.load_out) begin
            r_out_value <= result;
            r_out_err   <= r_err;
        end
    end

    assign o_value = r_out_value;
    assign o_error = r_out_err;

`ifndef SYNTHESIS
    a_refused_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_err) |=> (r_seed == $past(r_seed)))
        else $error("lcg_datapath: refused word changed the state");

    a_result_below_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && !r_err) |-> ({1'b0, result} < r_m))
        else $error("lcg_datapath: committed value not below modulus");

    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_out_value == r_seed))
        else $error("lcg_datapath: output value differs from committed state");
`endif

endmodule
`default_nettype wire

// ===== rtl/lcg_modmul_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_modmul_generator
// Linear congruential generator, next = (seed * a + c) mod m, general modulus,
// with a bit-serial shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_cmd     in   valid/ready    mode, seed_value[WIDTH-1:0]
//  o_res     out  valid/ready    value[WIDTH-1:0], error
//  i_cfg_*   in   write enable   idx 0 multiplier, 1 increment, 2 modulus
//
//  Advance word: after accept, the multiplier takes one step per multiplier
//  bit (separate accumulate and double adders), then adds c, then commits.
//  Load word or refused word: skips the multiply and goes straight to commit.
//  One word in flight; a new word is taken once the previous one is
//  committed to the output register, even while that result waits.
//  A stalled output holds the next result in the commit state.
//  Reset (synchronous) clears state to zero and loads default config.
// ----------------------------------------------------------------------------
module lcg_modmul_generator #(
    parameter int WIDTH = 48
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    lcg_in_if.sink                        i_cmd,
    lcg_out_if.source                     o_res,
    input  wire                           i_cfg_we,
    input  wire  [lcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [WIDTH:0]                i_cfg_data
);

    lcg_pkg::t_dp_cmd cmd;
    lcg_pkg::t_dp_sts sts;

    logic             in_ready;
    logic             out_valid;
    logic [WIDTH-1:0] value;
    logic             error;

    lcg_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lcg_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_cmd.mode),
        .i_seed_value (i_cmd.seed_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_value      (value),
        .o_error      (error)
    );

    assign i_cmd.ready = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.value = value;
    assign o_res.error = error;

endmodule
`default_nettype wire
